/* design/plcg_pkg.sv */
package plcg_pkg;

    localparam int FracBits = 16;
    localparam int PosW     = 32;
    localparam int DiffW    = PosW + 1;
    localparam int MagW     = PosW;
    localparam int SqW      = 2 * MagW;
    localparam int SumW     = SqW + 2;
    localparam int RootW    = SumW / 2;
    localparam int LimW     = 33;
    localparam int PenW     = 34;
    localparam int NormW    = 18;
    localparam int BncW     = 17;
    localparam int IdxW     = 16;
    localparam int NumW     = MagW + FracBits;
    localparam int QW       = FracBits + 1;
    localparam int RootPipe = RootW;
    localparam int DivPipe  = QW;
    localparam int BitW     = 6;

    localparam logic [1:0] ModeRodBit    = 2'b01;
    localparam logic [1:0] ModeAnchorBit = 2'b10;

    typedef struct packed {
        logic            is_rod;
        logic            anchor;
        logic [IdxW-1:0] first_index;
        logic [IdxW-1:0] second_index;
        logic [LimW-1:0] limit_length;
        logic [BncW-1:0] bounce;
        logic [2:0]      neg;
    } t_side;

    typedef struct packed {
        logic [SumW-1:0]  rem;
        logic [RootW-1:0] root;
    } t_root;

    typedef struct packed {
        logic [NumW+RootW-1:0] rem;
        logic [QW-1:0]         q;
    } t_quo;

endpackage

/* design/plcg_root_cell.sv */
module plcg_root_cell
    import plcg_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [BitW-1:0] i_bit,
    input  t_root           i_d,
    output t_root           o_d
);
    logic [SumW+1:0] w_trial;
    logic [SumW+1:0] w_rem;
    t_root           n_d;
    t_root           r_d;

    always_comb begin
        w_rem   = {2'b00, i_d.rem};
        w_trial = ({2'b00, {{(SumW - RootW){1'b0}}, i_d.root}} << (i_bit + BitW'(1)))
                  | ({{(SumW + 1){1'b0}}, 1'b1} << {i_bit, 1'b0});
        n_d = i_d;
        if (w_rem >= w_trial) begin
            n_d.rem  = SumW'(w_rem - w_trial);
            n_d.root = i_d.root | (RootW'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

/* design/plcg_div_cell.sv */
module plcg_div_cell
    import plcg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [BitW-1:0]  i_bit,
    input  logic [RootW-1:0] i_den,
    input  t_quo             i_d,
    output t_quo             o_d
);
    logic [NumW+RootW:0] w_sub;
    t_quo                n_d;
    t_quo                r_d;

    always_comb begin
        w_sub = (NumW + RootW + 1)'(i_den) << i_bit;
        n_d = i_d;
        if ({1'b0, i_d.rem} >= w_sub) begin
            n_d.rem = (NumW + RootW)'({1'b0, i_d.rem} - w_sub);
            n_d.q   = i_d.q | (QW'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

/* design/particle_link_contact_generator_top.sv */
// Channel | Direction | Handshake             | Payload
// input   | in        | i_valid / o_ready     | mode, indices, positions, limit, bounce
// output  | out       | o_valid / i_ready     | contact, indices, normal, penetration, bounce
// One transaction is accepted per cycle while the pipe is not stalled; each passes through
// three square and sum stages, 33 square root cells, one compare stage and
// 17 divide cells in each of three parallel chains, one chain per axis.
// The whole pipe advances together and stalls only when the output
// register holds a result that is not taken. Reset clears valid bits only.
module particle_link_contact_generator_top
    import plcg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_mode,
    input  logic [IdxW-1:0]        i_first_index,
    input  logic [IdxW-1:0]        i_second_index,
    input  logic signed [PosW-1:0] i_first_x,
    input  logic signed [PosW-1:0] i_first_y,
    input  logic signed [PosW-1:0] i_first_z,
    input  logic signed [PosW-1:0] i_second_x,
    input  logic signed [PosW-1:0] i_second_y,
    input  logic signed [PosW-1:0] i_second_z,
    input  logic [LimW-1:0]        i_limit_length,
    input  logic [BncW-1:0]        i_bounce,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_has_contact,
    output logic [IdxW-1:0]        o_out_first_index,
    output logic [IdxW-1:0]        o_out_second_index,
    output logic                   o_second_present,
    output logic signed [NormW-1:0] o_normal_x,
    output logic signed [NormW-1:0] o_normal_y,
    output logic signed [NormW-1:0] o_normal_z,
    output logic [PenW-1:0]        o_penetration,
    output logic [BncW-1:0]        o_out_bounce
);
    localparam int Depth = 3 + RootPipe + 1 + DivPipe;

    logic en;
    logic [Depth-1:0] r_vld;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[Depth-1];

    // Stage 1: differences and magnitudes.
    logic [DiffW-1:0] w_d [3];
    logic [MagW-1:0]  r_mag [3];
    t_side            r_s1, r_s2, r_s3;
    t_side            w_s0;

    always_comb begin
        w_d[0] = DiffW'($signed(i_second_x)) - DiffW'($signed(i_first_x));
        w_d[1] = DiffW'($signed(i_second_y)) - DiffW'($signed(i_first_y));
        w_d[2] = DiffW'($signed(i_second_z)) - DiffW'($signed(i_first_z));
        w_s0.is_rod       = |(i_mode & ModeRodBit);
        w_s0.anchor       = |(i_mode & ModeAnchorBit);
        w_s0.first_index  = i_first_index;
        w_s0.second_index = i_second_index;
        w_s0.limit_length = i_limit_length;
        w_s0.bounce       = i_bounce;
        w_s0.neg = {w_d[2][DiffW-1], w_d[1][DiffW-1], w_d[0][DiffW-1]};
    end

    logic [SqW-1:0]  r_sq [3];
    logic [SumW-1:0] r_sum;
    logic [MagW-1:0] r_mag2 [3];
    logic [MagW-1:0] r_mag3 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i]  <= w_d[i][DiffW-1] ? MagW'(-w_d[i]) : MagW'(w_d[i]);
                r_sq[i]   <= r_mag[i] * r_mag[i];
                r_mag2[i] <= r_mag[i];
                r_mag3[i] <= r_mag2[i];
            end
            r_sum <= SumW'(r_sq[0]) + SumW'(r_sq[1]) + SumW'(r_sq[2]);
            r_s1 <= w_s0;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // Square root chain, one result bit per cell, side data riding along.
    t_root w_rt [RootPipe+1];
    t_side r_rs [RootPipe];
    logic [MagW-1:0] r_rm [RootPipe][3];

    assign w_rt[0] = '{rem: r_sum, root: '0};

    for (genvar k = 0; k < RootPipe; k++) begin : g_root
        plcg_root_cell u_cell (
            .i_clk(i_clk), .i_en(en), .i_bit(BitW'(RootPipe - 1 - k)),
            .i_d(w_rt[k]), .o_d(w_rt[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rs[k] <= (k == 0) ? r_s3 : r_rs[k == 0 ? 0 : k-1];
                for (int i = 0; i < 3; i++) begin
                    r_rm[k][i] <= (k == 0) ? r_mag3[i] : r_rm[k == 0 ? 0 : k-1][i];
                end
            end
        end
    end

    // Compare stage.
    logic [RootW-1:0] w_dist;
    logic [RootW:0]   w_lim;
    t_side            r_cs;
    logic [RootW-1:0] r_dist;
    logic             r_contact, r_ge;
    logic [PenW-1:0]  r_pen;
    logic [MagW-1:0]  r_cm [3];

    assign w_dist = w_rt[RootPipe].root;
    assign w_lim  = (RootW + 1)'(r_rs[RootPipe-1].limit_length);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cs   <= r_rs[RootPipe-1];
            r_dist <= w_dist;
            r_ge   <= {1'b0, w_dist} >= w_lim;
            r_contact <= r_rs[RootPipe-1].is_rod ? ({1'b0, w_dist} != w_lim)
                                                 : ({1'b0, w_dist} >= w_lim);
            r_pen <= ({1'b0, w_dist} >= w_lim) ? PenW'({1'b0, w_dist} - w_lim)
                                               : PenW'(w_lim - {1'b0, w_dist});
            for (int i = 0; i < 3; i++) begin
                r_cm[i] <= r_rm[RootPipe-1][i];
            end
        end
    end

    // Divide chains, one quotient bit per cell per axis.
    t_quo w_q [3][DivPipe+1];
    logic [RootW-1:0] r_den [DivPipe];
    t_side r_ds [DivPipe];
    logic  r_dc [DivPipe];
    logic  r_dg [DivPipe];
    logic [PenW-1:0] r_dp [DivPipe];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign w_q[a][0] = '{rem: (NumW + RootW)'({r_cm[a], {FracBits{1'b0}}}), q: '0};
        for (genvar k = 0; k < DivPipe; k++) begin : g_div
            plcg_div_cell u_cell (
                .i_clk(i_clk), .i_en(en), .i_bit(BitW'(DivPipe - 1 - k)),
                .i_den((k == 0) ? r_dist : r_den[k == 0 ? 0 : k-1]),
                .i_d(w_q[a][k]), .o_d(w_q[a][k+1])
            );
        end
    end

    for (genvar k = 0; k < DivPipe; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_den[k] <= (k == 0) ? r_dist    : r_den[k == 0 ? 0 : k-1];
                r_ds[k]  <= (k == 0) ? r_cs      : r_ds[k == 0 ? 0 : k-1];
                r_dc[k]  <= (k == 0) ? r_contact : r_dc[k == 0 ? 0 : k-1];
                r_dg[k]  <= (k == 0) ? r_ge      : r_dg[k == 0 ? 0 : k-1];
                r_dp[k]  <= (k == 0) ? r_pen     : r_dp[k == 0 ? 0 : k-1];
            end
        end
    end

    // Output assembly into the last pipe slot.
    t_side            w_fs;
    logic [NormW-1:0] w_n [3];
    logic [QW-1:0]    w_qc;
    logic [RootW-1:0] w_fd;

    assign w_fs = r_ds[DivPipe-1];
    assign w_fd = r_den[DivPipe-1];

    always_comb begin
        w_qc = '0;
        for (int i = 0; i < 3; i++) begin
            w_qc = w_q[i][DivPipe].q;
            if (w_qc > QW'(1 << FracBits)) begin
                w_qc = QW'(1 << FracBits);
            end
            if (w_fd == '0) begin
                w_qc = '0;
            end
            w_n[i] = (w_fs.neg[i] ^ !r_dg[DivPipe-1]) ? -NormW'(w_qc) : NormW'(w_qc);
        end
    end

    always_comb begin
        o_has_contact      = r_dc[DivPipe-1];
        o_out_first_index  = '0;
        o_out_second_index = '0;
        o_second_present   = 1'b0;
        o_normal_x         = '0;
        o_normal_y         = '0;
        o_normal_z         = '0;
        o_penetration      = '0;
        o_out_bounce       = '0;
        if (r_dc[DivPipe-1]) begin
            o_out_first_index  = w_fs.first_index;
            o_out_second_index = w_fs.anchor ? '0 : w_fs.second_index;
            o_second_present   = !w_fs.anchor;
            o_normal_x         = w_n[0];
            o_normal_y         = w_n[1];
            o_normal_z         = w_n[2];
            o_penetration      = r_dp[DivPipe-1];
            if (!w_fs.is_rod) begin
                o_out_bounce = (w_fs.bounce > BncW'(1 << FracBits))
                               ? BncW'(1 << FracBits) : w_fs.bounce;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("Result dropped while stalled.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_contact |-> o_penetration == '0)
        else $error("Penetration without contact.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("Ready does not follow output room.");
endmodule

/* verif/particle_link_contact_generator_top_tb.sv */
module particle_link_contact_generator_top_tb;
    import plcg_pkg::*;

    localparam logic [1:0] ModeCable       = 2'd0;
    localparam logic [1:0] ModeRod         = 2'd1;
    localparam logic [1:0] ModeCableAnchor = 2'd2;
    localparam logic [1:0] ModeRodAnchor   = 2'd3;
    localparam int         Latency         = 54;
    localparam int         StallLimit      = 2000;

    typedef struct packed {
        logic [1:0]             mode;
        logic [IdxW-1:0]        first_index;
        logic [IdxW-1:0]        second_index;
        logic signed [PosW-1:0] fx, fy, fz, sx, sy, sz;
        logic [LimW-1:0]        limit_length;
        logic [BncW-1:0]        bounce;
    } t_link;

    typedef struct packed {
        logic                    has_contact;
        logic [IdxW-1:0]         first_index;
        logic [IdxW-1:0]         second_index;
        logic                    second_present;
        logic signed [NormW-1:0] nx, ny, nz;
        logic [PenW-1:0]         penetration;
        logic [BncW-1:0]         bounce;
    } t_contact;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [1:0]              i_mode;
    logic [IdxW-1:0]         i_first_index;
    logic [IdxW-1:0]         i_second_index;
    logic signed [PosW-1:0]  i_first_x, i_first_y, i_first_z;
    logic signed [PosW-1:0]  i_second_x, i_second_y, i_second_z;
    logic [LimW-1:0]         i_limit_length;
    logic [BncW-1:0]         i_bounce;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_has_contact;
    logic [IdxW-1:0]         o_out_first_index;
    logic [IdxW-1:0]         o_out_second_index;
    logic                    o_second_present;
    logic signed [NormW-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic [PenW-1:0]         o_penetration;
    logic [BncW-1:0]         o_out_bounce;

    t_contact expected_contacts[$];
    int       error_count;
    int       sent_count;
    int       contact_count;
    int       idle_cycles;
    bit       idling_on;
    bit       timed_out;

    particle_link_contact_generator_top i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [RootW-1:0] floor_root(logic [SumW-1:0] value);
        logic [RootW-1:0] root;
        logic [RootW-1:0] trial;
        root = '0;
        for (int b = RootW - 1; b >= 0; b--) begin
            trial = root | (RootW'(1) << b);
            if ((SumW + 2)'(trial) * (SumW + 2)'(trial) <= (SumW + 2)'(value)) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic logic signed [NormW-1:0] unit_axis(logic signed [DiffW-1:0] d,
                                                          logic [RootW-1:0] distance);
        logic [79:0] mag;
        logic [79:0] q;
        mag = d < 0 ? 80'(-d) : 80'(d);
        if (distance == 0) begin
            return '0;
        end
        q = (mag << FracBits) / 80'(distance);
        if (q > (80'(1) << FracBits)) begin
            q = 80'(1) << FracBits;
        end
        return d < 0 ? -NormW'(q) : NormW'(q);
    endfunction

    function automatic t_contact predict_contact(t_link l);
        t_contact c;
        logic signed [DiffW-1:0] dx, dy, dz;
        logic [SumW-1:0]         sum;
        logic [RootW-1:0]        distance;
        logic                    is_rod;
        logic                    touching;
        logic [RootW:0]          pen;
        c = '0;
        is_rod = l.mode[0];
        dx = DiffW'(l.sx) - DiffW'(l.fx);
        dy = DiffW'(l.sy) - DiffW'(l.fy);
        dz = DiffW'(l.sz) - DiffW'(l.fz);
        sum = SumW'(dx) * SumW'(dx) + SumW'(dy) * SumW'(dy) + SumW'(dz) * SumW'(dz);
        distance = floor_root(sum);
        touching = is_rod ? (RootW'(l.limit_length) != distance)
                          : (distance >= RootW'(l.limit_length));
        if (!touching) begin
            return c;
        end
        c.nx = unit_axis(dx, distance);
        c.ny = unit_axis(dy, distance);
        c.nz = unit_axis(dz, distance);
        if (distance >= RootW'(l.limit_length)) begin
            pen = (RootW + 1)'(distance) - (RootW + 1)'(l.limit_length);
        end else begin
            pen = (RootW + 1)'(l.limit_length) - (RootW + 1)'(distance);
            c.nx = -c.nx;
            c.ny = -c.ny;
            c.nz = -c.nz;
        end
        c.penetration = pen > {PenW{1'b1}} ? {PenW{1'b1}} : PenW'(pen);
        c.bounce = is_rod ? '0 : (l.bounce > 17'd65536 ? 17'd65536 : l.bounce);
        c.has_contact = 1'b1;
        c.first_index = l.first_index;
        c.second_index = l.mode[1] ? '0 : l.second_index;
        c.second_present = ~l.mode[1];
        return c;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        error_count++;
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 contact_count, field, got, want);
    endtask

    task automatic send_link(t_link l);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= l.mode;
        i_first_index  <= l.first_index;
        i_second_index <= l.second_index;
        i_first_x      <= l.fx;
        i_first_y      <= l.fy;
        i_first_z      <= l.fz;
        i_second_x     <= l.sx;
        i_second_y     <= l.sy;
        i_second_z     <= l.sz;
        i_limit_length <= l.limit_length;
        i_bounce       <= l.bounce;
        do @(posedge i_clk); while (!o_ready);
        expected_contacts.push_back(predict_contact(l));
        sent_count++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [PosW-1:0] rand_coord(int spread);
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return PosW'($signed($urandom_range(0, 2 * spread))) - PosW'(spread);
        endcase
    endfunction

    function automatic t_link rand_link();
        t_link l;
        logic [RootW-1:0] distance;
        logic signed [DiffW-1:0] dx, dy, dz;
        l.mode = 2'($urandom_range(0, 3));
        l.first_index = IdxW'($urandom());
        l.second_index = IdxW'($urandom());
        l.fx = rand_coord(1 << 20);
        l.fy = rand_coord(1 << 20);
        l.fz = rand_coord(1 << 20);
        if ($urandom_range(0, 9) == 0) begin
            l.sx = l.fx;
            l.sy = l.fy;
            l.sz = l.fz;
        end else begin
            l.sx = rand_coord(1 << 20);
            l.sy = rand_coord(1 << 20);
            l.sz = rand_coord(1 << 20);
        end
        l.bounce = BncW'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 65536));
        dx = DiffW'(l.sx) - DiffW'(l.fx);
        dy = DiffW'(l.sy) - DiffW'(l.fy);
        dz = DiffW'(l.sz) - DiffW'(l.fz);
        distance = floor_root(SumW'(dx) * SumW'(dx) + SumW'(dy) * SumW'(dy)
                              + SumW'(dz) * SumW'(dz));
        case ($urandom_range(0, 4))
            0: l.limit_length = LimW'(distance);
            1: l.limit_length = LimW'(distance) + LimW'($urandom_range(0, 1000)) - 33'd500;
            2: l.limit_length = {$urandom(), 1'($urandom())};
            3: l.limit_length = LimW'($urandom_range(0, 1 << 22));
            default: l.limit_length = LimW'(distance) + 33'd1;
        endcase
        return l;
    endfunction

    task automatic test_extremes();
        t_link l;
        logic [1:0] modes [4] = '{ModeCable, ModeRod, ModeCableAnchor, ModeRodAnchor};
        for (int m = 0; m < 4; m++) begin
            l = '0;
            l.mode = modes[m];
            l.first_index = 16'hffff;
            l.second_index = 16'hffff;
            l.fx = 32'sh80000000;
            l.fy = 32'sh80000000;
            l.fz = 32'sh80000000;
            l.sx = 32'sh7fffffff;
            l.sy = 32'sh7fffffff;
            l.sz = 32'sh7fffffff;
            l.bounce = 17'h1ffff;
            send_link(l);
            l.limit_length = {LimW{1'b1}};
            send_link(l);
        end
    endtask

    task automatic test_special_cases();
        t_link l;
        logic [1:0] modes [4] = '{ModeCable, ModeRod, ModeCableAnchor, ModeRodAnchor};
        for (int m = 0; m < 4; m++) begin
            l = '0;
            l.mode = modes[m];
            l.first_index = 16'h1234;
            l.second_index = 16'h5678;
            l.fx = 32'sh00010000;
            l.sx = 32'sh00010000;
            l.bounce = 17'd65536;
            send_link(l);
            l.limit_length = 33'h10000;
            send_link(l);
            l.sx = 32'sh00030000;
            l.sy = -32'sh00020000;
            send_link(l);
            l.limit_length = 33'h40000;
            send_link(l);
        end
        l.mode = ModeCable;
        l.limit_length = '0;
        l.bounce = 17'd65537;
        send_link(l);
    endtask

    task automatic test_random(int count, bit with_idle);
        idling_on = with_idle;
        repeat (count) send_link(rand_link());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = ModeCable;
        i_first_index = '0;
        i_second_index = '0;
        i_first_x = '0;
        i_first_y = '0;
        i_first_z = '0;
        i_second_x = '0;
        i_second_y = '0;
        i_second_z = '0;
        i_limit_length = '0;
        i_bounce = '0;
        error_count = 0;
        sent_count = 0;
        contact_count = 0;
        idling_on = 1'b1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_special_cases();
        test_random(1700, 1'b1);
        test_random(300, 1'b0);
        i_valid <= 1'b0;
        idling_on = 1'b0;
        while (expected_contacts.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (Latency + 10) @(negedge i_clk);
        if (expected_contacts.size() != 0) begin
            error_count++;
            $display("%0d expected results never arrived", expected_contacts.size());
        end
        $display("Sent %0d links across all four modes, checked %0d results.",
                 sent_count, contact_count);
        if (error_count == 0 && !timed_out) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_contact want;
        if (i_rst_n && o_valid && i_ready) begin
            contact_count++;
            if (expected_contacts.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_contacts.pop_front();
                if (o_has_contact !== want.has_contact)
                    report_mismatch("has_contact", o_has_contact, want.has_contact);
                if (o_out_first_index !== want.first_index)
                    report_mismatch("first_index", o_out_first_index, want.first_index);
                if (o_out_second_index !== want.second_index)
                    report_mismatch("second_index", o_out_second_index, want.second_index);
                if (o_second_present !== want.second_present)
                    report_mismatch("second_present", o_second_present, want.second_present);
                if (o_normal_x !== want.nx) report_mismatch("normal_x", o_normal_x, want.nx);
                if (o_normal_y !== want.ny) report_mismatch("normal_y", o_normal_y, want.ny);
                if (o_normal_z !== want.nz) report_mismatch("normal_z", o_normal_z, want.nz);
                if (o_penetration !== want.penetration)
                    report_mismatch("penetration", o_penetration, want.penetration);
                if (o_out_bounce !== want.bounce)
                    report_mismatch("bounce", o_out_bounce, want.bounce);
            end
        end
    end

    // The count restarts whenever either channel moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                timed_out = 1'b1;
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

/* files.f */
design/plcg_pkg.sv
design/plcg_root_cell.sv
design/plcg_div_cell.sv
design/particle_link_contact_generator_top.sv
verif/particle_link_contact_generator_top_tb.sv
